// ===== sv/ssc_pkg.sv =====
package ssc_pkg;

  localparam int MAX_ITEMS  = 24;
  localparam int HALF_DEPTH = 4096;

  localparam int WEIGHT_W = 32;
  localparam int CAP_W    = 41;
  localparam int SUM_W    = 37;
  localparam int V_W      = CAP_W + 1;
  localparam int COUNT_W  = 25;

  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int HALF_W = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int LEN_W  = HALF_W + 1;
  localparam int M_W    = HALF_W + 2;

  function automatic int accept_limit_f();
    int n;
    n = MAX_ITEMS;
    while (n > 0 && ((64'd1 << (n >> 1)) > 64'(HALF_DEPTH))) n--;
    return n;
  endfunction

  localparam int ACCEPT_LIMIT = accept_limit_f();

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_PASS,
    S_WLD,
    S_MRA,
    S_MRB,
    S_MWR,
    S_MSTART,
    S_SR,
    S_SA,
    S_BCHK,
    S_BCMP
  } state_t;

endpackage

// ===== sv/ssc_ram.sv =====
module ssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/subset_sum_count_mitm.sv =====
// Subset sum counter, meet in the middle.
// Load: one weight per cycle on in_item_weight, transferred at a clock edge
// with start high and busy low. in_last_item marks the final item of a set.
// Items beyond the store capacity are dropped; a flagged one still closes
// the set.
// Evaluate: after the last item busy stays high while the first-half sums
// are built by repeated merges (2^(h+1) - 2 merged entries in total for
// h = n/2, rounded down), and each of the 2^(n-h) second-half sums is
// built item bit by item bit (S_SR, S_SA) and then counted by a binary
// search (S_BCHK, S_BCMP) over the sorted table. Both phases are bound by
// the single read port of each RAM.
// Result: out_valid strobes for one cycle with out_subset_count; the
// receiver cannot stall, and the block accepts the next item in that cycle.
// Config: cfg_we writes the signed capacity from cfg_data; write it only
// while the block is idle.
// Reset: rst_n low clears item count, capacity and control state; RAM
// contents are not cleared.
module subset_sum_count_mitm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ssc_pkg::WEIGHT_W-1:0] in_item_weight,
  input  logic                              in_last_item,
  output logic                              out_valid,
  output logic [ssc_pkg::COUNT_W-1:0]       out_subset_count,
  input  logic                              cfg_we,
  input  logic signed [ssc_pkg::CAP_W-1:0]  cfg_data
);

  localparam int SUM_W  = ssc_pkg::SUM_W;
  localparam int WW     = ssc_pkg::WEIGHT_W;
  localparam int HW     = ssc_pkg::HALF_W;
  localparam int LW     = ssc_pkg::LEN_W;
  localparam int MW     = ssc_pkg::M_W;
  localparam int CW     = ssc_pkg::CNT_W;
  localparam int IW     = ssc_pkg::IDX_W;
  localparam int VW     = ssc_pkg::V_W;

  ssc_pkg::state_t state_r, state_nxt;

  logic signed [ssc_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]    item_count_r, item_count_nxt;
  logic [CW-1:0]    h_r, h_nxt, r_r, r_nxt;
  logic [CW-1:0]    k_r, k_nxt, j_r, j_nxt;
  logic [LW-1:0]    len_r, len_nxt, a_r, a_nxt, b_r, b_nxt, o_r, o_nxt;
  logic [LW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [MW-1:0]    m_r, m_nxt;
  logic [SUM_W-1:0] w_r, w_nxt, va_r, va_nxt, s_r, s_nxt;
  logic [VW-1:0]    v_r, v_nxt;
  logic [ssc_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ssc_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic             item_we;
  logic [IW-1:0]    item_waddr, item_raddr;
  logic [WW-1:0]    item_rdata;
  logic             half_we;
  logic [HW:0]      half_waddr, half_raddr;
  logic [SUM_W-1:0] half_wdata, half_rdata;

  logic             accept;
  logic [CW-1:0]    n_new;
  logic [SUM_W-1:0] item_sext, vb_w;
  logic [LW-1:0]    mid;
  logic [MW-1:0]    top;
  logic             take_a;
  logic             src_bank, fin_bank;
  logic             pass_done, search_gt, m_last;

  ssc_ram #(.WIDTH(WW), .DEPTH(ssc_pkg::MAX_ITEMS)) u_items (
    .clk(clk), .we(item_we), .waddr(item_waddr), .wdata(in_item_weight),
    .raddr(item_raddr), .rdata(item_rdata)
  );

  ssc_ram #(.WIDTH(SUM_W), .DEPTH(2 * ssc_pkg::HALF_DEPTH)) u_half (
    .clk(clk), .we(half_we), .waddr(half_waddr), .wdata(half_wdata),
    .raddr(half_raddr), .rdata(half_rdata)
  );

  assign busy      = (state_r != ssc_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign item_we   = accept && (item_count_r < CW'(ssc_pkg::ACCEPT_LIMIT));
  assign item_waddr = item_count_r[IW-1:0];
  assign n_new     = item_we ? (item_count_r + CW'(1)) : item_count_r;
  assign item_sext = {{(SUM_W - WW){item_rdata[WW-1]}}, item_rdata};
  assign vb_w      = half_rdata + w_r;
  assign take_a    = (a_r < len_r) &&
                     ((b_r >= len_r) || ($signed(va_r) <= $signed(vb_w)));
  assign mid       = LW'((lo_r + hi_r) >> 1);
  assign top       = MW'(1) << r_r;
  assign src_bank  = k_r[0];
  assign fin_bank  = h_r[0];
  assign pass_done = ((o_r + LW'(1)) == LW'(len_r << 1));
  assign search_gt = $signed({{(VW - SUM_W){half_rdata[SUM_W-1]}}, half_rdata})
                     > $signed(v_r);
  assign m_last    = ((m_r + MW'(1)) == top);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssc_pkg::S_IDLE:   if (accept && in_last_item) state_nxt = ssc_pkg::S_INIT;
      ssc_pkg::S_INIT:   state_nxt = ssc_pkg::S_PASS;
      ssc_pkg::S_PASS:   state_nxt = (k_r == h_r) ? ssc_pkg::S_MSTART : ssc_pkg::S_WLD;
      ssc_pkg::S_WLD:    state_nxt = ssc_pkg::S_MRA;
      ssc_pkg::S_MRA:    state_nxt = ssc_pkg::S_MRB;
      ssc_pkg::S_MRB:    state_nxt = ssc_pkg::S_MWR;
      ssc_pkg::S_MWR:    state_nxt = pass_done ? ssc_pkg::S_PASS : ssc_pkg::S_MRA;
      ssc_pkg::S_MSTART: state_nxt = ssc_pkg::S_SR;
      ssc_pkg::S_SR:     state_nxt = (j_r == r_r) ? ssc_pkg::S_BCHK : ssc_pkg::S_SA;
      ssc_pkg::S_SA:     state_nxt = ssc_pkg::S_SR;
      ssc_pkg::S_BCHK: begin
        if (lo_r < hi_r) begin
          state_nxt = ssc_pkg::S_BCMP;
        end else begin
          state_nxt = m_last ? ssc_pkg::S_IDLE : ssc_pkg::S_MSTART;
        end
      end
      ssc_pkg::S_BCMP:   state_nxt = ssc_pkg::S_BCHK;
      default:           state_nxt = ssc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_count_nxt = item_count_r;
    h_nxt = h_r;
    r_nxt = r_r;
    k_nxt = k_r;
    j_nxt = j_r;
    len_nxt = len_r;
    a_nxt = a_r;
    b_nxt = b_r;
    o_nxt = o_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    m_nxt = m_r;
    w_nxt = w_r;
    va_nxt = va_r;
    s_nxt = s_r;
    v_nxt = v_r;
    total_nxt = total_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    item_raddr = '0;
    half_we = 1'b0;
    half_waddr = '0;
    half_wdata = '0;
    half_raddr = '0;
    case (state_r)
      ssc_pkg::S_IDLE: begin
        item_count_nxt = n_new;
        if (accept && in_last_item) begin
          h_nxt = n_new >> 1;
          r_nxt = n_new - (n_new >> 1);
        end
      end
      ssc_pkg::S_INIT: begin
        half_we = 1'b1;
        k_nxt = '0;
        len_nxt = LW'(1);
        total_nxt = '0;
        m_nxt = '0;
      end
      ssc_pkg::S_PASS: begin
        item_raddr = IW'(k_r);
      end
      ssc_pkg::S_WLD: begin
        w_nxt = item_sext;
        a_nxt = '0;
        b_nxt = '0;
        o_nxt = '0;
      end
      ssc_pkg::S_MRA: begin
        half_raddr = {src_bank, a_r[HW-1:0]};
      end
      ssc_pkg::S_MRB: begin
        half_raddr = {src_bank, b_r[HW-1:0]};
        va_nxt = half_rdata;
      end
      ssc_pkg::S_MWR: begin
        half_we = 1'b1;
        half_waddr = {~src_bank, o_r[HW-1:0]};
        half_wdata = take_a ? va_r : vb_w;
        if (take_a) begin
          a_nxt = a_r + LW'(1);
        end else begin
          b_nxt = b_r + LW'(1);
        end
        o_nxt = o_r + LW'(1);
        if (pass_done) begin
          len_nxt = LW'(len_r << 1);
          k_nxt = k_r + CW'(1);
        end
      end
      ssc_pkg::S_MSTART: begin
        s_nxt = '0;
        j_nxt = '0;
      end
      ssc_pkg::S_SR: begin
        item_raddr = IW'(h_r + j_r);
        if (j_r == r_r) begin
          lo_nxt = '0;
          hi_nxt = len_r;
          v_nxt = VW'(cap_r) - {{(VW - SUM_W){s_r[SUM_W-1]}}, s_r};
        end
      end
      ssc_pkg::S_SA: begin
        if (|(m_r & (MW'(1) << j_r))) begin
          s_nxt = s_r + item_sext;
        end
        j_nxt = j_r + CW'(1);
      end
      ssc_pkg::S_BCHK: begin
        half_raddr = {fin_bank, mid[HW-1:0]};
        if (!(lo_r < hi_r)) begin
          total_nxt = total_r + ssc_pkg::COUNT_W'(lo_r);
          m_nxt = m_r + MW'(1);
          if (m_last) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = total_r + ssc_pkg::COUNT_W'(lo_r);
            item_count_nxt = '0;
          end
        end
      end
      ssc_pkg::S_BCMP: begin
        if (search_gt) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + LW'(1);
        end
      end
      default: begin
        item_count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssc_pkg::S_IDLE;
      cap_r <= '0;
      item_count_r <= '0;
      out_valid_r <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      item_count_r <= item_count_nxt;
      out_valid_r <= out_valid_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    r_r <= r_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    len_r <= len_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    o_r <= o_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    m_r <= m_nxt;
    w_r <= w_nxt;
    va_r <= va_nxt;
    s_r <= s_nxt;
    v_r <= v_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_subset_count = out_count_r;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ssc_pkg::S_IDLE && item_count_r == '0))
    else $error("result strobe outside idle");
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_item) |=> (busy && !out_valid))
    else $error("last item did not start evaluation");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    item_count_r <= CW'(ssc_pkg::ACCEPT_LIMIT))
    else $error("item count above limit");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== tb/sv/subset_sum_count_mitm_tb.sv =====
module subset_sum_count_mitm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [ssc_pkg::WEIGHT_W-1:0] in_item_weight = '0;
  logic                                in_last_item = 1'b0;
  logic                                out_valid;
  logic [ssc_pkg::COUNT_W-1:0]         out_subset_count;
  logic                                cfg_we = 1'b0;
  logic signed [ssc_pkg::CAP_W-1:0]    cfg_data = '0;

  always #1 clk = ~clk;

  subset_sum_count_mitm u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item_weight(in_item_weight), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_subset_count(out_subset_count),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  typedef struct {
    bit                                  set_cap;
    logic signed [ssc_pkg::CAP_W-1:0]    cap;
    logic signed [ssc_pkg::WEIGHT_W-1:0] weight;
    bit                                  last;
    bit                                  known;
    logic [ssc_pkg::COUNT_W-1:0]         count;
  } dir_row_t;

  localparam logic signed [ssc_pkg::CAP_W-1:0] CAP_MIN =
    {1'b1, {(ssc_pkg::CAP_W-1){1'b0}}};
  localparam logic signed [ssc_pkg::CAP_W-1:0] CAP_MAX =
    {1'b0, {(ssc_pkg::CAP_W-1){1'b1}}};
  localparam logic signed [ssc_pkg::WEIGHT_W-1:0] W_MIN =
    {1'b1, {(ssc_pkg::WEIGHT_W-1){1'b0}}};
  localparam logic signed [ssc_pkg::WEIGHT_W-1:0] W_MAX =
    {1'b0, {(ssc_pkg::WEIGHT_W-1){1'b1}}};
  localparam int N_DIR = 11;

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, '0, 32'sd0, 1'b1, 1'b1, 25'd2},
    '{1'b0, '0, W_MIN, 1'b1, 1'b1, 25'd2},
    '{1'b0, '0, W_MAX, 1'b1, 1'b1, 25'd1},
    '{1'b1, CAP_MIN, W_MIN, 1'b1, 1'b1, 25'd0},
    '{1'b1, CAP_MAX, W_MAX, 1'b0, 1'b0, 25'd0},
    '{1'b0, '0, W_MAX, 1'b1, 1'b1, 25'd4},
    '{1'b1, 41'sd5, 32'sd3, 1'b0, 1'b0, 25'd0},
    '{1'b0, '0, -32'sd1, 1'b0, 1'b0, 25'd0},
    '{1'b0, '0, 32'sd4, 1'b0, 1'b0, 25'd0},
    '{1'b0, '0, 32'sd1, 1'b0, 1'b0, 25'd0},
    '{1'b0, '0, -32'sd5, 1'b1, 1'b0, 25'd0}
  };

  longint                      load_weights [ssc_pkg::MAX_ITEMS];
  int                          load_fill = 0;
  longint                      cur_capacity = 0;
  logic [ssc_pkg::COUNT_W-1:0] pending_counts [$];
  int                          mismatches = 0;
  int                          counts_seen = 0;
  int                          items_sent = 0;
  int                          sets_sent = 0;
  int                          burst_left = 0;

  function automatic logic [ssc_pkg::COUNT_W-1:0] count_fitting_subsets();
    int     h;
    int     r;
    int     len;
    int     a;
    int     b;
    int     lo;
    int     hi;
    int     mid;
    longint sums [$];
    longint merged [$];
    longint s;
    longint v;
    longint total;
    h = load_fill / 2;
    r = load_fill - h;
    sums = '{0};
    for (int k = 0; k < h; k++) begin
      len = sums.size();
      merged = {};
      a = 0;
      b = 0;
      while (a < len || b < len) begin
        if (a < len && (b >= len || sums[a] <= sums[b] + load_weights[k])) begin
          merged = {merged, sums[a]};
          a++;
        end else begin
          merged = {merged, sums[b] + load_weights[k]};
          b++;
        end
      end
      sums = merged;
    end
    len = sums.size();
    total = 0;
    for (int m = 0; m < (1 << r); m++) begin
      s = 0;
      for (int j = 0; j < r; j++)
        if ((m >> j) & 1) s += load_weights[h + j];
      v = cur_capacity - s;
      lo = 0;
      hi = len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (sums[mid] > v) hi = mid;
        else lo = mid + 1;
      end
      total += lo;
    end
    return total[ssc_pkg::COUNT_W-1:0];
  endfunction

  task automatic send_item(input logic signed [ssc_pkg::WEIGHT_W-1:0] w,
                           input bit last, input bit known,
                           input logic [ssc_pkg::COUNT_W-1:0] count);
    logic [ssc_pkg::COUNT_W-1:0] predicted;
    start          <= 1'b1;
    in_item_weight <= w;
    in_last_item   <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    if (load_fill < ssc_pkg::ACCEPT_LIMIT) begin
      load_weights[load_fill] = w;
      load_fill++;
    end
    if (last) begin
      predicted = count_fitting_subsets();
      pending_counts = {pending_counts, (known ? count : predicted)};
      load_fill = 0;
      sets_sent++;
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 6);
    end
  endtask

  task automatic write_capacity(input logic signed [ssc_pkg::CAP_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_capacity = v;
  endtask

  function automatic logic signed [ssc_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(0, 1) ? W_MIN : W_MAX;
      3: return $urandom_range(0, 2000) - 1000;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic signed [ssc_pkg::CAP_W-1:0] pick_capacity();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return CAP_MIN;
      1: return CAP_MAX;
      2: return raw[ssc_pkg::CAP_W-1:0];
      3: return $signed(raw[34:0]);
      4: return $signed($urandom_range(0, 90)) - 30;
      default: return $signed(raw[ssc_pkg::CAP_W-1:0]) >>> $urandom_range(0, 40);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      counts_seen++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected count %0d", out_subset_count);
      end else begin
        if (out_subset_count !== pending_counts[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("count mismatch: expected %0d, got %0d",
                     pending_counts[0], out_subset_count);
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cap) write_capacity(dir_rows[i].cap);
      send_item(dir_rows[i].weight, dir_rows[i].last, dir_rows[i].known,
                dir_rows[i].count);
      pace();
    end
    write_capacity(CAP_MAX);
    for (int i = 0; i < ssc_pkg::MAX_ITEMS + 2; i++)
      send_item(pick_weight(), i == ssc_pkg::MAX_ITEMS + 1, 1'b1, 25'd16777216);
    write_capacity(CAP_MIN + 1);
    while (items_sent < 1550) begin
      if (sets_sent % 15 == 0) write_capacity(pick_capacity());
      case ($urandom_range(0, 99)) inside
        [0:79]:  n = $urandom_range(1, 8);
        [80:96]: n = $urandom_range(9, 13);
        default: n = $urandom_range(14, 16);
      endcase
      for (int i = 0; i < n; i++) begin
        send_item(pick_weight(), i == n - 1, 1'b0, '0);
        pace();
      end
    end
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d weights in %0d sets sent, %0d counts checked, %0d mismatches",
             items_sent, sets_sent, counts_seen, mismatches);
    if (mismatches == 0 && pending_counts.size() == 0)
      $display("subset_sum_count_mitm regression: pass");
    else
      $display("subset_sum_count_mitm regression: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d counts outstanding", pending_counts.size());
    $display("subset_sum_count_mitm regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ssc_pkg.sv
sv/ssc_ram.sv
sv/subset_sum_count_mitm.sv
tb/sv/subset_sum_count_mitm_tb.sv
